### hw/rtl/sos_pkg.sv
// shared types, register indexes and helpers for the string occurrence scanner
`timescale 1ns / 1ps

package sos_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgMode     = 2'd0;
  localparam logic [1:0] CfgLength   = 2'd1;
  localparam logic [1:0] CfgPatLow   = 2'd2;
  localparam logic [1:0] CfgPatHigh  = 2'd3;
  localparam int         CfgIdxW     = 2;
  localparam int         CfgDataW    = 64;

  // operating modes
  localparam logic       ModeExact    = 1'b0;
  localparam logic       ModeContains = 1'b1;

  // printable range and fixed pattern storage
  localparam logic [7:0] PrintLo     = 8'd32;
  localparam logic [7:0] PrintHi     = 8'd126;
  localparam int         PatStoreLen = 16;
  localparam int         LenW        = 5;
  localparam int         ResOffW     = 32;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic               found;
    logic [ResOffW-1:0] offset;
  } res_t;

  function automatic logic is_printable(byte_t c);
    return (c >= PrintLo) && (c <= PrintHi);
  endfunction

  // pattern byte that lines up with window slot j for a pattern of length len
  function automatic byte_t aligned_byte(logic [8*PatStoreLen-1:0] pat,
                                         logic [LenW-1:0] len, int j);
    int i;
    i = int'(len) - 1 - j;
    if (i >= 0 && i < PatStoreLen) begin
      return pat[8*i +: 8];
    end
    return 8'd0;
  endfunction

endpackage

### hw/rtl/string_occurrence_scanner_core.sv
// top level of the string occurrence scanner: window compare and result buffering
`timescale 1ns / 1ps

// streaming first-occurrence search of a pattern of up to PATTERN_MAX bytes
// in channel: one buffer byte per item (data_byte_i, last_byte_i), valid/ready
// out channel: found_o and match_offset_o, at most one item per buffer
// cfg channel: register index and data, always ready; write only when idle
//   index 0 mode, 1 pattern length, 2 pattern bytes 0..7, 3 pattern bytes 8..15
// exact mode reports the match start when the match ends the buffer or is
// followed by a non-printable byte; contains mode reports the start of the
// printable run holding the match start
// a buffer with no match gives a not-found item on its last byte
// the result for an accepted byte is registered in the output register, or in the skid register while it is held
// throughput: one byte per cycle while in_ready_o is high, set by the single compare stage between
// the window registers and the output register
// a stalled receiver holds the output register; a skid register takes one
// more result, and in_ready_o drops only while that skid register is full
// reset clears windows, counter, report flag, registers and both buffers
module string_occurrence_scanner_core #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sos_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sos_pkg::CfgDataW-1:0]    cfg_data_i,
  // byte stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [sos_pkg::ResOffW-1:0]     match_offset_o
);

  localparam int OffW = OFFSET_BITS;
  localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [OffW-1:0] CountMax = {OffW{1'b1}};

  // configuration registers
  logic                                   mode_q;
  logic [sos_pkg::LenW-1:0]               len_q;
  logic [8*sos_pkg::PatStoreLen-1:0]      pat_q;

  // per-buffer state
  sos_pkg::byte_t                         bw_q [PATTERN_MAX];
  sos_pkg::byte_t                         bw_d [PATTERN_MAX];
  logic [OffW-1:0]                        rsw_q [PATTERN_MAX];
  logic [OffW-1:0]                        rsw_d [PATTERN_MAX];
  logic [OffW-1:0]                        count_q, count_d;
  logic                                   rep_q, rep_d;

  // output register and skid stage
  sos_pkg::res_t                          out_q, out_d, skid_q, skid_d;
  logic                                   out_valid_q, out_valid_d;
  logic                                   skid_valid_q, skid_valid_d;

  // compare stage
  sos_pkg::byte_t                         bw_n [PATTERN_MAX+1];
  logic [OffW-1:0]                        rsw_n [PATTERN_MAX];
  sos_pkg::byte_t                         align [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]                 use_slot;
  logic [PATTERN_MAX-1:0]                 eq_now, eq_prev;
  logic                                   match_now, match_prev;
  logic                                   usable;
  logic [sos_pkg::LenW-1:0]               len_m1;
  logic [OffW-1:0]                        run_start;
  logic [OffW-1:0]                        hit_off;
  logic                                   hit, emit;
  sos_pkg::res_t                          res;
  logic                                   accept, take;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign take        = out_valid_q && out_ready_i;

  assign usable = (len_q != '0) && ({27'd0, len_q} <= 32'(PATTERN_MAX));
  assign len_m1 = len_q - sos_pkg::LenW'(1);

  // run start of this position looks only at the preceding byte
  always_comb begin
    if (count_q == '0 || !sos_pkg::is_printable(bw_q[0])) begin
      run_start = count_q;
    end else begin
      run_start = rsw_q[0];
    end
  end

  // windows as they stand after this byte is shifted in
  always_comb begin
    bw_n[0]  = data_byte_i;
    rsw_n[0] = run_start;
    for (int k = 1; k <= PATTERN_MAX; k++) begin
      bw_n[k] = bw_q[k-1];
    end
    for (int k = 1; k < PATTERN_MAX; k++) begin
      rsw_n[k] = rsw_q[k-1];
    end
  end

  // pattern reversed onto window slots; slot j holds pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      align[j]    = sos_pkg::aligned_byte(pat_q, len_q, j);
      use_slot[j] = j < int'(len_q);
      eq_now[j]   = (bw_n[j] == align[j]) || !use_slot[j];
      eq_prev[j]  = (bw_n[j+1] == align[j]) || !use_slot[j];
    end
  end

  // match ending on this byte, and match ending on the byte before it
  assign match_now  = &eq_now;
  assign match_prev = &eq_prev;

  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    if (!rep_q && usable) begin
      if (mode_q == sos_pkg::ModeExact) begin
        // exact: terminator check first, then end of buffer
        if (count_q >= OffW'(len_q) && !sos_pkg::is_printable(data_byte_i) &&
            match_prev) begin
          hit     = 1'b1;
          hit_off = count_q - OffW'(len_q);
        end else if (last_byte_i && count_q >= OffW'(len_m1) && match_now) begin
          hit     = 1'b1;
          hit_off = count_q - OffW'(len_m1);
        end
      end else begin
        // contains: report the run start of the match start
        if (count_q >= OffW'(len_m1) && match_now) begin
          hit     = 1'b1;
          hit_off = rsw_n[IdxW'(len_m1)];
        end
      end
    end
  end

  assign emit         = hit || (last_byte_i && !rep_q);
  assign res.found    = hit;
  assign res.offset   = hit ? sos_pkg::ResOffW'(hit_off) : '0;

  // buffer state update, cleared at the end of each buffer
  always_comb begin
    count_d = count_q;
    rep_d   = rep_q;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      bw_d[k]  = bw_q[k];
      rsw_d[k] = rsw_q[k];
    end
    if (accept) begin
      if (last_byte_i) begin
        count_d = '0;
        rep_d   = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
          bw_d[k]  = '0;
          rsw_d[k] = '0;
        end
      end else begin
        count_d = (count_q == CountMax) ? count_q : count_q + OffW'(1);
        rep_d   = rep_q || hit;
        for (int k = 0; k < PATTERN_MAX; k++) begin
          bw_d[k]  = bw_n[k];
          rsw_d[k] = rsw_n[k];
        end
      end
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept && emit;
        out_d       = res;
      end
    end else if (accept && emit) begin
      if (out_valid_q) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      len_q        <= '0;
      pat_q        <= '0;
      count_q      <= '0;
      rep_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        bw_q[k]  <= '0;
        rsw_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sos_pkg::CfgMode:    mode_q                    <= cfg_data_i[0];
          sos_pkg::CfgLength:  len_q                     <= cfg_data_i[sos_pkg::LenW-1:0];
          sos_pkg::CfgPatLow:  pat_q[sos_pkg::CfgDataW-1:0] <= cfg_data_i;
          sos_pkg::CfgPatHigh: pat_q[2*sos_pkg::CfgDataW-1:sos_pkg::CfgDataW] <= cfg_data_i;
          default: ;
        endcase
      end
      count_q      <= count_d;
      rep_q        <= rep_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      out_q        <= out_d;
      skid_q       <= skid_d;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        bw_q[k]  <= bw_d[k];
        rsw_q[k] <= rsw_d[k];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_q.found;
  assign match_offset_o = out_q.offset;

endmodule

### bench/sos_occurrence_checker.sv
// scoreboard for the string occurrence scanner: tracks the scan state and checks each result
`timescale 1ns / 1ps

module sos_occurrence_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [sos_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sos_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         found_i,
  input  logic [sos_pkg::ResOffW-1:0]  match_offset_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam int WinMax = sos_pkg::PatStoreLen;
  localparam longint unsigned PosMax = (64'd1 << sos_pkg::ResOffW) - 64'd1;

  logic                              mode_q;
  logic [sos_pkg::LenW-1:0]          len_q;
  logic [8*sos_pkg::PatStoreLen-1:0] pat_q;

  sos_pkg::byte_t  win_q [WinMax+1];
  longint unsigned run_win_q [WinMax];
  longint unsigned run_start_q;
  longint unsigned pos_q;
  bit              reported_q;

  sos_pkg::res_t expected_reports [$];

  function automatic bit text_char(sos_pkg::byte_t c);
    return (c >= sos_pkg::PrintLo) && (c <= sos_pkg::PrintHi);
  endfunction

  function automatic sos_pkg::byte_t pat_byte(int unsigned i);
    if (i < sos_pkg::PatStoreLen) return pat_q[8*i +: 8];
    return 8'h00;
  endfunction

  // pattern lined up with its last byte at window slot lag
  function automatic bit window_holds(int unsigned n, int unsigned lag);
    int unsigned i;
    int unsigned slot;
    for (i = 0; i < n; i++) begin
      slot = lag + n - 1 - i;
      if (slot > WinMax) return 1'b0;
      if (win_q[slot] != pat_byte(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    int k;
    for (k = 0; k <= WinMax; k++) win_q[k] = 8'h00;
    for (k = 0; k < WinMax; k++) run_win_q[k] = 0;
    run_start_q = 0;
    pos_q       = 0;
    reported_q  = 1'b0;
  endfunction

  // advance the scan by one byte, returns 1 when the byte yields a result
  function automatic bit scan_byte(sos_pkg::byte_t b, bit fin, output sos_pkg::res_t r);
    longint unsigned p;
    longint unsigned rs;
    longint unsigned off;
    int unsigned     n;
    int              k;
    bit              hit;
    bit              was;
    p   = pos_q;
    n   = 32'(len_q);
    hit = 1'b0;
    off = 0;
    // run start only looks at the byte before this one
    rs = (p == 0 || !text_char(win_q[0])) ? p : run_start_q;
    for (k = WinMax; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = b;
    for (k = WinMax - 1; k > 0; k--) run_win_q[k] = run_win_q[k-1];
    run_win_q[0] = rs;
    run_start_q  = rs;
    if (!reported_q && n != 0 && n <= WinMax) begin
      if (mode_q == sos_pkg::ModeExact) begin
        // a match closed by a non-printable byte wins over one ending on the last byte
        if (p >= n && !text_char(b) && window_holds(n, 1)) begin
          hit = 1'b1;
          off = p - n;
        end else if (fin && p + 1 >= n && window_holds(n, 0)) begin
          hit = 1'b1;
          off = p + 1 - n;
        end
      end else if (p + 1 >= n && window_holds(n, 0)) begin
        hit = 1'b1;
        off = run_win_q[n-1];
      end
    end
    pos_q = (p < PosMax) ? p + 1 : PosMax;
    was   = reported_q;
    if (hit) reported_q = 1'b1;
    if (fin) clear_scan();
    r.found  = hit;
    r.offset = off[sos_pkg::ResOffW-1:0];
    return hit || (fin && !was);
  endfunction

  function automatic void note_failure(string what);
    fail_count_o++;
    if (fail_count_o <= 10) $display("[%0t] %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sos_pkg::res_t got;
    sos_pkg::res_t want;
    if (!rst_ni) begin
      mode_q       = 1'b0;
      len_q        = '0;
      pat_q        = '0;
      clear_scan();
      expected_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          sos_pkg::CfgMode:    mode_q = cfg_data_i[0];
          sos_pkg::CfgLength:  len_q = cfg_data_i[sos_pkg::LenW-1:0];
          sos_pkg::CfgPatLow:  pat_q[63:0] = cfg_data_i;
          sos_pkg::CfgPatHigh: pat_q[127:64] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (scan_byte(data_byte_i, last_byte_i, want)) expected_reports.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got.found  = found_i;
        got.offset = match_offset_i;
        if (expected_reports.size() == 0) begin
          note_failure($sformatf("unexpected result found=%0b offset=%0d",
                                 got.found, got.offset));
        end else begin
          want = expected_reports.pop_front();
          if (got.found !== want.found || got.offset !== want.offset) begin
            note_failure($sformatf(
                "mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                want.found, want.offset, got.found, got.offset));
          end
        end
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

### bench/tb_string_occurrence_scanner_core.sv
// testbench top for the string occurrence scanner: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_string_occurrence_scanner_core;

  // pipeline delay from accepted byte to result, used by settle
  localparam int Latency    = 1;
  localparam int CycleLimit = 100000;

  typedef sos_pkg::byte_t byte_stream_t[$];

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [sos_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [sos_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [7:0]                   data_byte_i = '0;
  logic                         last_byte_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         found_o;
  logic [sos_pkg::ResOffW-1:0]  match_offset_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  // no idling on either side while set
  bit          steady = 1'b0;

  string_occurrence_scanner_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  sos_occurrence_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_i        (found_o),
    .match_offset_i (match_offset_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls about 30 percent of the time, never while steady
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 30);
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mixed byte: control, high, printable or a pattern letter
  function automatic sos_pkg::byte_t noise_byte();
    case ($urandom_range(0, 4))
      0: return sos_pkg::byte_t'($urandom_range(0, 31));
      1: return sos_pkg::byte_t'($urandom_range(127, 255));
      2: return sos_pkg::byte_t'($urandom_range(32, 126));
      default: return sos_pkg::byte_t'(8'h61 + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic byte_stream_t text(string s);
    byte_stream_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(sos_pkg::byte_t'(s[i]));
    return q;
  endfunction

  function automatic logic [8*sos_pkg::PatStoreLen-1:0] text_pattern(string s);
    logic [8*sos_pkg::PatStoreLen-1:0] p;
    p = '0;
    for (int i = 0; i < s.len() && i < sos_pkg::PatStoreLen; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  // one item on the byte channel; valid is only lowered for an idle gap, so it
  // never falls and rises within the same step
  task automatic send_byte(sos_pkg::byte_t b, logic fin);
    if (!steady) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_buffer(byte_stream_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // drop valid and hold off until every result is back, plus the pipeline delay
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sos_pkg::CfgIdxW-1:0] idx,
                           logic [sos_pkg::CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // all four registers; unused upper bits of mode and length carry junk
  task automatic load_config(logic mode, logic [sos_pkg::LenW-1:0] n,
                             logic [8*sos_pkg::PatStoreLen-1:0] pat);
    logic [sos_pkg::CfgDataW-1:0] word;
    word = {$urandom, $urandom};
    word[0] = mode;
    write_reg(sos_pkg::CfgMode, word);
    word = {$urandom, $urandom};
    word[sos_pkg::LenW-1:0] = n;
    write_reg(sos_pkg::CfgLength, word);
    write_reg(sos_pkg::CfgPatLow, pat[63:0]);
    write_reg(sos_pkg::CfgPatHigh, pat[127:64]);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    byte_stream_t                      stream;
    logic                              mode;
    logic [sos_pkg::LenW-1:0]          n;
    logic [8*sos_pkg::PatStoreLen-1:0] pat;
    bit                                letters;
    int unsigned                       count;
    int unsigned                       span;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // exact mode, three bytes
    load_config(sos_pkg::ModeExact, 5'd3, text_pattern("abc"));
    send_buffer(text("xabc\n"));   // match closed by a control byte
    send_buffer(text("abc"));      // match that ends the buffer
    send_buffer(text("abcd"));     // printable byte follows: not a whole string
    send_buffer(text("ab"));       // buffer too short for the pattern
    settle();

    // contains mode: offset is the start of the printable run, later bytes silent
    load_config(sos_pkg::ModeContains, 5'd3, text_pattern("abc"));
    send_buffer(text("\001 zabcabc"));
    settle();

    // zero byte pattern: match before the last byte beats the one ending on it
    load_config(sos_pkg::ModeExact, 5'd1, '0);
    stream = {8'h00, 8'h00};
    send_buffer(stream);
    settle();

    // zero length never matches
    load_config(sos_pkg::ModeContains, 5'd0, '1);
    stream = {8'hFF, 8'h41};
    send_buffer(stream);
    settle();

    // overlong pattern never matches, even against an all-zero window
    load_config(sos_pkg::ModeExact, 5'd31, '0);
    stream = {8'h00};
    send_buffer(stream);

    // random phases, each with its own setting
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      steady = (phase == 5);
      mode = 1'($urandom_range(0, 1));
      case (phase)
        0: begin
          mode = sos_pkg::ModeExact;
          n    = 5'd16;
        end
        1: begin
          mode = sos_pkg::ModeContains;
          n    = 5'd16;
        end
        2: n = 5'd0;
        3: n = sos_pkg::LenW'($urandom_range(17, 31));
        default: n = ($urandom_range(0, 3) != 0) ? sos_pkg::LenW'($urandom_range(1, 4))
                                                  : sos_pkg::LenW'($urandom_range(5, 16));
      endcase
      letters = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < sos_pkg::PatStoreLen; i++) begin
        pat[8*i +: 8] = letters ? sos_pkg::byte_t'(8'h61 + $urandom_range(0, 2))
                                : noise_byte();
      end
      load_config(mode, n, pat);

      count = 0;
      while (count < 50) begin
        stream.delete();
        span = (n == 0 || n > sos_pkg::PatStoreLen) ? $urandom_range(1, 6) : 32'(n);
        if ($urandom_range(0, 9) < 7) begin
          // well-formed: lead-in of letters and noise bytes, the pattern, then an optional ending
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0) begin
              stream.push_back(noise_byte());
            end else begin
              stream.push_back(sos_pkg::byte_t'(8'h61 + $urandom_range(0, 2)));
            end
          end
          for (int i = 0; i < span; i++) stream.push_back(pat[8*i +: 8]);
          // now and then cut the pattern short
          if ($urandom_range(0, 4) == 0 && stream.size() > 1) void'(stream.pop_back());
          case ($urandom_range(0, 2))
            0: begin
              stream.push_back(sos_pkg::byte_t'($urandom_range(0, 31)));
              repeat ($urandom_range(0, 4)) stream.push_back(noise_byte());
            end
            1: ;
            default: repeat ($urandom_range(1, 4)) stream.push_back(noise_byte());
          endcase
        end else begin
          repeat ($urandom_range(1, 12)) stream.push_back(noise_byte());
        end
        send_buffer(stream);
        count += stream.size();
        // now and then the sender holds off until the result queue has drained
        if ($urandom_range(0, 9) == 0) settle();
      end
    end
    steady = 1'b0;
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sos_pkg.sv
hw/rtl/string_occurrence_scanner_core.sv
bench/sos_occurrence_checker.sv
bench/tb_string_occurrence_scanner_core.sv
